/* src/midi_track_event_parser_defines.svh */
// Assertion macros for the MIDI track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define MTEP_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mtep assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define MTEP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mtep assertion failed");

`endif

/* src/mtep_pkg.sv */
package mtep_pkg;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_FIRST,
        PH_SECOND,
        PH_MTYPE,
        PH_MLEN,
        PH_TEMPO,
        PH_SXLEN,
        PH_SXDATA,
        PH_SKIP,
        PH_EMIT_RD,
        PH_EMIT_PUT
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CHAN  = 3'd0,
        KIND_TEMPO = 3'd1,
        KIND_SYSEX = 3'd2,
        KIND_EOT   = 3'd3,
        KIND_END   = 3'd4,
        KIND_ERR   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        FUNC_DATA    = 2'd0,
        FUNC_END     = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        OUT_CHAN2_RS,
        OUT_CHAN2,
        OUT_CHAN3,
        OUT_TEMPO,
        OUT_SX_EMPTY,
        OUT_SX_BYTE,
        OUT_EOT,
        OUT_END,
        OUT_ERR
    } out_sel_t;

    localparam logic [7:0] META_LEAD     = 8'hFF;
    localparam logic [7:0] SYSEX_F0      = 8'hF0;
    localparam logic [7:0] SYSEX_F7      = 8'hF7;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_PRESSURE  = 4'hD;
    localparam logic [3:0] NIB_SYSTEM    = 4'hF;
    localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;
    localparam logic [27:0] TEMPO_LEN    = 28'd3;

    typedef struct packed {
        logic     restart;
        logic     vlq_take;
        logic     vlq_clear;
        logic     tick_add;
        logic     rs_load;
        logic     rs_clear;
        logic     cur_from_rs;
        logic     cur_from_byte;
        logic     first_load;
        logic     meta_load;
        logic     rem_load_acc;
        logic     rem_load_tempo;
        logic     rem_dec;
        logic     tempo_clear;
        logic     tempo_shift;
        logic     fill_clear;
        logic     fill_write;
        logic     emit_clear;
        logic     emit_rd;
        logic     emit_inc;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
        logic vlq_done;
        logic vlq_over;
        logic byte_data;
        logic byte_meta;
        logic byte_sysex;
        logic byte_chan;
        logic rs_zero;
        logic rs_two_byte;
        logic cur_two_byte;
        logic tempo_meta;
        logic eot_meta;
        logic len_zero;
        logic len_too_long;
        logic rem_last;
        logic emit_last;
    } stat_t;

endpackage

/* src/mtep_ctrl.sv */
module mtep_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_func,
    input  logic             m_ready,
    input  mtep_pkg::stat_t  st,
    output mtep_pkg::cmd_t   cmd
);

    mtep_pkg::phase_t state_reg, state_next;
    logic             finished_reg, finished_next;
    logic             out_free;
    logic             item;
    logic             take;
    mtep_pkg::func_t  func;

    assign func     = mtep_pkg::func_t'(s_func);
    assign out_free = !st.out_valid || m_ready;
    assign s_ready  = out_free && (state_reg != mtep_pkg::PH_EMIT_RD)
                      && (state_reg != mtep_pkg::PH_EMIT_PUT);
    assign item     = s_valid && s_ready;
    assign take     = item && (func == mtep_pkg::FUNC_DATA) && !finished_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mtep_pkg::PH_DELTA;
            finished_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            finished_reg <= finished_next;
        end
    end

    // next state
    always_comb begin
        state_next    = state_reg;
        finished_next = finished_reg;
        priority if (item) begin
            if (func == mtep_pkg::FUNC_RESTART) begin
                state_next    = mtep_pkg::PH_DELTA;
                finished_next = 1'b0;
            end else if (func == mtep_pkg::FUNC_END) begin
                finished_next = 1'b1;
            end else if (take) begin
                unique case (state_reg)
                    mtep_pkg::PH_DELTA: begin
                        if (st.vlq_over) finished_next = 1'b1;
                        else if (st.vlq_done) state_next = mtep_pkg::PH_STATUS;
                    end
                    mtep_pkg::PH_STATUS: begin
                        priority if (st.byte_data) begin
                            if (st.rs_zero) finished_next = 1'b1;
                            else if (st.rs_two_byte) state_next = mtep_pkg::PH_DELTA;
                            else state_next = mtep_pkg::PH_SECOND;
                        end else if (st.byte_meta) begin
                            state_next = mtep_pkg::PH_MTYPE;
                        end else if (st.byte_sysex) begin
                            state_next = mtep_pkg::PH_SXLEN;
                        end else if (st.byte_chan) begin
                            state_next = mtep_pkg::PH_FIRST;
                        end else begin
                            finished_next = 1'b1;
                        end
                    end
                    mtep_pkg::PH_FIRST: begin
                        state_next = st.cur_two_byte ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SECOND;
                    end
                    mtep_pkg::PH_SECOND: state_next = mtep_pkg::PH_DELTA;
                    mtep_pkg::PH_MTYPE:  state_next = mtep_pkg::PH_MLEN;
                    mtep_pkg::PH_MLEN: begin
                        priority if (st.vlq_over) finished_next = 1'b1;
                        else if (!st.vlq_done) state_next = state_reg;
                        else if (st.tempo_meta) state_next = mtep_pkg::PH_TEMPO;
                        else if (st.eot_meta) finished_next = 1'b1;
                        else if (st.len_zero) state_next = mtep_pkg::PH_DELTA;
                        else state_next = mtep_pkg::PH_SKIP;
                    end
                    mtep_pkg::PH_TEMPO: begin
                        if (st.rem_last) state_next = mtep_pkg::PH_DELTA;
                    end
                    mtep_pkg::PH_SXLEN: begin
                        priority if (st.vlq_over) finished_next = 1'b1;
                        else if (!st.vlq_done) state_next = state_reg;
                        else if (st.len_too_long) state_next = mtep_pkg::PH_SKIP;
                        else if (st.len_zero) state_next = mtep_pkg::PH_DELTA;
                        else state_next = mtep_pkg::PH_SXDATA;
                    end
                    mtep_pkg::PH_SXDATA: begin
                        if (st.rem_last) state_next = mtep_pkg::PH_EMIT_RD;
                    end
                    mtep_pkg::PH_SKIP: begin
                        if (st.rem_last) state_next = mtep_pkg::PH_DELTA;
                    end
                    default: state_next = mtep_pkg::PH_DELTA;
                endcase
            end
        end else if (state_reg == mtep_pkg::PH_EMIT_RD) begin
            state_next = mtep_pkg::PH_EMIT_PUT;
        end else if ((state_reg == mtep_pkg::PH_EMIT_PUT) && out_free) begin
            state_next = st.emit_last ? mtep_pkg::PH_DELTA : mtep_pkg::PH_EMIT_RD;
        end
    end

    // datapath commands
    always_comb begin
        cmd         = '0;
        cmd.out_sel = mtep_pkg::OUT_ERR;
        priority if (item) begin
            if (func == mtep_pkg::FUNC_RESTART) begin
                cmd.restart = 1'b1;
            end else if ((func == mtep_pkg::FUNC_END) && !finished_reg) begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = mtep_pkg::OUT_END;
            end else if (take) begin
                unique case (state_reg)
                    mtep_pkg::PH_DELTA: begin
                        cmd.vlq_take = 1'b1;
                        if (st.vlq_over) cmd.out_load = 1'b1;
                        else if (st.vlq_done) cmd.tick_add = 1'b1;
                    end
                    mtep_pkg::PH_STATUS: begin
                        priority if (st.byte_data) begin
                            if (st.rs_zero) begin
                                cmd.out_load = 1'b1;
                            end else begin
                                cmd.cur_from_rs = 1'b1;
                                cmd.first_load  = 1'b1;
                                if (st.rs_two_byte) begin
                                    cmd.out_load  = 1'b1;
                                    cmd.out_sel   = mtep_pkg::OUT_CHAN2_RS;
                                    cmd.vlq_clear = 1'b1;
                                end
                            end
                        end else if (st.byte_meta) begin
                            cmd.out_load = 1'b0;
                        end else if (st.byte_sysex) begin
                            cmd.cur_from_byte = 1'b1;
                            cmd.vlq_clear     = 1'b1;
                        end else if (st.byte_chan) begin
                            cmd.rs_load       = 1'b1;
                            cmd.cur_from_byte = 1'b1;
                        end else begin
                            cmd.out_load = 1'b1;
                        end
                    end
                    mtep_pkg::PH_FIRST: begin
                        cmd.first_load = 1'b1;
                        if (st.cur_two_byte) begin
                            cmd.out_load  = 1'b1;
                            cmd.out_sel   = mtep_pkg::OUT_CHAN2;
                            cmd.vlq_clear = 1'b1;
                        end
                    end
                    mtep_pkg::PH_SECOND: begin
                        cmd.out_load  = 1'b1;
                        cmd.out_sel   = mtep_pkg::OUT_CHAN3;
                        cmd.vlq_clear = 1'b1;
                    end
                    mtep_pkg::PH_MTYPE: begin
                        cmd.meta_load = 1'b1;
                        cmd.vlq_clear = 1'b1;
                    end
                    mtep_pkg::PH_MLEN: begin
                        cmd.vlq_take = 1'b1;
                        priority if (st.vlq_over) begin
                            cmd.out_load = 1'b1;
                        end else if (!st.vlq_done) begin
                            cmd.out_load = 1'b0;
                        end else if (st.tempo_meta) begin
                            cmd.tempo_clear    = 1'b1;
                            cmd.rem_load_tempo = 1'b1;
                        end else if (st.eot_meta) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = mtep_pkg::OUT_EOT;
                        end else begin
                            cmd.rem_load_acc = 1'b1;
                            cmd.vlq_clear    = st.len_zero;
                        end
                    end
                    mtep_pkg::PH_TEMPO: begin
                        cmd.tempo_shift = 1'b1;
                        cmd.rem_dec     = 1'b1;
                        if (st.rem_last) begin
                            cmd.out_load  = 1'b1;
                            cmd.out_sel   = mtep_pkg::OUT_TEMPO;
                            cmd.vlq_clear = 1'b1;
                        end
                    end
                    mtep_pkg::PH_SXLEN: begin
                        cmd.vlq_take = 1'b1;
                        priority if (st.vlq_over) begin
                            cmd.out_load = 1'b1;
                        end else if (!st.vlq_done) begin
                            cmd.out_load = 1'b0;
                        end else if (st.len_too_long) begin
                            cmd.rem_load_acc = 1'b1;
                        end else begin
                            cmd.fill_clear   = 1'b1;
                            cmd.rem_load_acc = 1'b1;
                            if (st.len_zero) begin
                                cmd.out_load  = 1'b1;
                                cmd.out_sel   = mtep_pkg::OUT_SX_EMPTY;
                                cmd.rs_clear  = 1'b1;
                                cmd.vlq_clear = 1'b1;
                            end
                        end
                    end
                    mtep_pkg::PH_SXDATA: begin
                        cmd.fill_write = 1'b1;
                        cmd.rem_dec    = 1'b1;
                        if (st.rem_last) begin
                            cmd.rs_clear   = 1'b1;
                            cmd.vlq_clear  = 1'b1;
                            cmd.emit_clear = 1'b1;
                        end
                    end
                    mtep_pkg::PH_SKIP: begin
                        cmd.rem_dec   = 1'b1;
                        cmd.vlq_clear = st.rem_last;
                    end
                    default: cmd.vlq_clear = 1'b1;
                endcase
            end
        end else if (state_reg == mtep_pkg::PH_EMIT_RD) begin
            cmd.emit_rd = 1'b1;
        end else if ((state_reg == mtep_pkg::PH_EMIT_PUT) && out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = mtep_pkg::OUT_SX_BYTE;
            cmd.emit_inc = 1'b1;
        end
    end

endmodule

/* src/mtep_dp.sv */
module mtep_dp #(
    parameter int MAX_EVENT_BYTES = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       s_data_byte,
    input  mtep_pkg::cmd_t   cmd,
    output mtep_pkg::stat_t  st,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [2:0]       m_kind,
    output logic [31:0]      m_abs_tick,
    output logic [7:0]       m_status_byte,
    output logic [7:0]       m_data_first,
    output logic [7:0]       m_data_second,
    output logic [5:0]       m_event_length,
    output logic [23:0]      m_tempo_us_per_qn,
    output logic             m_last
);

    localparam int AW = (MAX_EVENT_BYTES > 1) ? $clog2(MAX_EVENT_BYTES) : 1;

    logic [27:0]   acc_reg;
    logic [27:0]   acc_next;
    logic [2:0]    cnt_reg;
    logic [31:0]   tick_reg;
    logic [7:0]    rs_reg;
    logic [7:0]    cur_reg;
    logic [7:0]    first_reg;
    logic [7:0]    meta_reg;
    logic [27:0]   rem_reg;
    logic [23:0]   tempo_reg;
    logic [AW-1:0] fill_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    mem [MAX_EVENT_BYTES];
    logic [31:0]   fill_len;

    logic              valid_reg;
    mtep_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]        status_reg, status_next;
    logic [7:0]        d1_reg, d1_next;
    logic [7:0]        d2_reg, d2_next;
    logic [5:0]        len_reg, len_next;
    logic [23:0]       tempo_out_reg, tempo_out_next;
    logic              last_reg, last_next;

    assign acc_next = {acc_reg[20:0], s_data_byte[6:0]};
    assign fill_len = 32'(fill_reg) + 32'd1;

    always_comb begin
        st              = '0;
        st.out_valid    = valid_reg;
        st.vlq_done     = !s_data_byte[7];
        st.vlq_over     = s_data_byte[7] && ((cnt_reg + 3'd1) >= mtep_pkg::VLQ_MAX_BYTES);
        st.byte_data    = !s_data_byte[7];
        st.byte_meta    = s_data_byte == mtep_pkg::META_LEAD;
        st.byte_sysex   = (s_data_byte == mtep_pkg::SYSEX_F0)
                          || (s_data_byte == mtep_pkg::SYSEX_F7);
        st.byte_chan    = s_data_byte[7] && (s_data_byte[7:4] != mtep_pkg::NIB_SYSTEM);
        st.rs_zero      = rs_reg == 8'd0;
        st.rs_two_byte  = (rs_reg[7:4] == mtep_pkg::NIB_PROGRAM)
                          || (rs_reg[7:4] == mtep_pkg::NIB_PRESSURE);
        st.cur_two_byte = (cur_reg[7:4] == mtep_pkg::NIB_PROGRAM)
                          || (cur_reg[7:4] == mtep_pkg::NIB_PRESSURE);
        st.tempo_meta   = (meta_reg == mtep_pkg::META_TEMPO) && (acc_next == 28'd3);
        st.eot_meta     = meta_reg == mtep_pkg::META_EOT;
        st.len_zero     = acc_next == 28'd0;
        st.len_too_long = 32'(acc_next) >= 32'(MAX_EVENT_BYTES);
        st.rem_last     = rem_reg == 28'd1;
        st.emit_last    = (32'(idx_reg) + 32'd1) == 32'(fill_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            tick_reg  <= '0;
            rs_reg    <= '0;
            cur_reg   <= '0;
            first_reg <= '0;
            meta_reg  <= '0;
            rem_reg   <= '0;
            tempo_reg <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.vlq_clear) begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end else if (cmd.vlq_take) begin
                acc_reg <= acc_next;
                cnt_reg <= (st.vlq_done || st.vlq_over) ? 3'd0 : cnt_reg + 3'd1;
            end
            if (cmd.tick_add) tick_reg <= tick_reg + {4'd0, acc_next};
            if (cmd.rs_clear) rs_reg <= '0;
            else if (cmd.rs_load) rs_reg <= s_data_byte;
            if (cmd.cur_from_rs) cur_reg <= rs_reg;
            else if (cmd.cur_from_byte) cur_reg <= s_data_byte;
            if (cmd.first_load) first_reg <= s_data_byte;
            if (cmd.meta_load) meta_reg <= s_data_byte;
            if (cmd.rem_load_acc) rem_reg <= acc_next;
            else if (cmd.rem_load_tempo) rem_reg <= mtep_pkg::TEMPO_LEN;
            else if (cmd.rem_dec) rem_reg <= rem_reg - 28'd1;
            if (cmd.tempo_clear) tempo_reg <= '0;
            else if (cmd.tempo_shift) tempo_reg <= {tempo_reg[15:0], s_data_byte};
            if (cmd.fill_clear) fill_reg <= '0;
            else if (cmd.fill_write) fill_reg <= fill_reg + AW'(1);
            if (cmd.emit_clear) idx_reg <= '0;
            else if (cmd.emit_inc) idx_reg <= idx_reg + AW'(1);
        end
    end

    // sysex buffer
    always_ff @(posedge aclk) begin
        if (cmd.fill_write) mem[fill_reg] <= s_data_byte;
        if (cmd.emit_rd) rd_data_reg <= mem[idx_reg];
    end

    always_comb begin
        kind_next      = mtep_pkg::KIND_ERR;
        status_next    = '0;
        d1_next        = '0;
        d2_next        = '0;
        len_next       = '0;
        tempo_out_next = '0;
        last_next      = 1'b1;
        unique case (cmd.out_sel)
            mtep_pkg::OUT_CHAN2_RS: begin
                kind_next   = mtep_pkg::KIND_CHAN;
                status_next = rs_reg;
                d1_next     = s_data_byte;
                len_next    = 6'd2;
            end
            mtep_pkg::OUT_CHAN2: begin
                kind_next   = mtep_pkg::KIND_CHAN;
                status_next = cur_reg;
                d1_next     = s_data_byte;
                len_next    = 6'd2;
            end
            mtep_pkg::OUT_CHAN3: begin
                kind_next   = mtep_pkg::KIND_CHAN;
                status_next = cur_reg;
                d1_next     = first_reg;
                d2_next     = s_data_byte;
                len_next    = 6'd3;
            end
            mtep_pkg::OUT_TEMPO: begin
                kind_next      = mtep_pkg::KIND_TEMPO;
                tempo_out_next = {tempo_reg[15:0], s_data_byte};
            end
            mtep_pkg::OUT_SX_EMPTY: begin
                kind_next   = mtep_pkg::KIND_SYSEX;
                status_next = cur_reg;
                len_next    = 6'd1;
            end
            mtep_pkg::OUT_SX_BYTE: begin
                kind_next   = mtep_pkg::KIND_SYSEX;
                status_next = cur_reg;
                d1_next     = rd_data_reg;
                len_next    = fill_len[5:0];
                last_next   = st.emit_last;
            end
            mtep_pkg::OUT_EOT: kind_next = mtep_pkg::KIND_EOT;
            mtep_pkg::OUT_END: kind_next = mtep_pkg::KIND_END;
            mtep_pkg::OUT_ERR: kind_next = mtep_pkg::KIND_ERR;
            default:           kind_next = mtep_pkg::KIND_ERR;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            kind_reg      <= kind_next;
            m_abs_tick    <= tick_reg;
            status_reg    <= status_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            len_reg       <= len_next;
            tempo_out_reg <= tempo_out_next;
            last_reg      <= last_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_kind            = kind_reg;
    assign m_status_byte     = status_reg;
    assign m_data_first      = d1_reg;
    assign m_data_second     = d2_reg;
    assign m_event_length    = len_reg;
    assign m_tempo_us_per_qn = tempo_out_reg;
    assign m_last            = last_reg;

endmodule

/* src/midi_track_event_parser.sv */
// Standard MIDI File track event parser. Feed one track byte per transaction
// (s_func data), then an end-of-data transaction; s_func restart clears the
// parser for a new track. Ordinary bytes are taken at one per cycle while
// the result register is free or m_ready is high; a result that waits for
// m_ready holds the next byte off. When the last data byte of a buffered
// sysex arrives, the input stalls while the buffer is read back byte by byte
// (a registered buffer read, then a load of the result register), and also
// during any output backpressure. Sysex longer than MAX_EVENT_BYTES - 1
// bytes is skipped. The sysex buffer needs no clearing after reset.
`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser #(
    parameter int MAX_EVENT_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_abs_tick,
    output logic [7:0]  m_status_byte,
    output logic [7:0]  m_data_first,
    output logic [7:0]  m_data_second,
    output logic [5:0]  m_event_length,
    output logic [23:0] m_tempo_us_per_qn,
    output logic        m_last
);

    mtep_pkg::cmd_t  cmd;
    mtep_pkg::stat_t st;

    mtep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mtep_dp #(
        .MAX_EVENT_BYTES (MAX_EVENT_BYTES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_data_byte       (s_data_byte),
        .cmd               (cmd),
        .st                (st),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_kind            (m_kind),
        .m_abs_tick        (m_abs_tick),
        .m_status_byte     (m_status_byte),
        .m_data_first      (m_data_first),
        .m_data_second     (m_data_second),
        .m_event_length    (m_event_length),
        .m_tempo_us_per_qn (m_tempo_us_per_qn),
        .m_last            (m_last)
    );

    `MTEP_ASSERT_SAME(a_ready_needs_room, s_ready, !m_valid || m_ready)
    `MTEP_ASSERT_SAME(a_single_is_last, m_valid && (m_kind != mtep_pkg::KIND_SYSEX), m_last)
    `MTEP_ASSERT_NEXT(a_sysex_drain_blocks, cmd.fill_write && st.rem_last, !s_ready)

endmodule
